/* src/rsc_pkg.sv */
`default_nettype none
package rsc_pkg;

   localparam int unsigned WORD_W = 32;

   // quotient sweep: 33-bit dividend padded to a whole number of steps
   localparam int unsigned DIV_W        = 36;
   localparam int unsigned DIV_STEP     = 4;
   localparam int unsigned DIV_STAGES   = DIV_W / DIV_STEP;

   // setup, multiply, dividend prep, divide steps, apply
   localparam int unsigned EDGE_STAGES  = 3 + DIV_STAGES + 1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   typedef struct packed {
      logic signed [WORD_W-1:0] src_left;
      logic signed [WORD_W-1:0] src_top;
      logic signed [WORD_W-1:0] src_right;
      logic signed [WORD_W-1:0] src_bottom;
      logic signed [WORD_W-1:0] dst_left;
      logic signed [WORD_W-1:0] dst_top;
      logic signed [WORD_W-1:0] dst_right;
      logic signed [WORD_W-1:0] dst_bottom;
      logic signed [WORD_W-1:0] clip_left;
      logic signed [WORD_W-1:0] clip_top;
      logic signed [WORD_W-1:0] clip_right;
      logic signed [WORD_W-1:0] clip_bottom;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] new_src_left;
      logic signed [WORD_W-1:0] new_src_top;
      logic signed [WORD_W-1:0] new_src_right;
      logic signed [WORD_W-1:0] new_src_bottom;
      logic signed [WORD_W-1:0] new_dst_left;
      logic signed [WORD_W-1:0] new_dst_top;
      logic signed [WORD_W-1:0] new_dst_right;
      logic signed [WORD_W-1:0] new_dst_bottom;
      logic                     visible;
      logic                     status;
   } rsp_type;

   // rectangles as they travel between edge units; index 0..3 = l,t,r,b
   typedef struct packed {
      logic                           status;
      logic [3:0][WORD_W-1:0]         src;
      logic [3:0][WORD_W-1:0]         dst;
      logic [3:0][WORD_W-1:0]         clip;
   } job_type;

endpackage
`default_nettype wire

/* src/rsc_if.sv */
`default_nettype none
interface rsc_req_if;
   logic             valid;
   logic             ready;
   rsc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rsc_rsp_if;
   logic             valid;
   logic             ready;
   rsc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/rsc_edge.sv */
`default_nettype none
// One edge trim: setup, multiply, dividend prep, restoring divide, apply.
module rsc_edge #(
   parameter int unsigned FRACTION_BITS = 16,
   parameter int unsigned EDGE          = 0     // 0 left, 1 top, 2 right, 3 bottom
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire rsc_pkg::job_type in_job,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output rsc_pkg::job_type      out_job
);

   localparam int unsigned W  = rsc_pkg::WORD_W;
   localparam int unsigned DW = rsc_pkg::DIV_W;
   localparam int unsigned NS = rsc_pkg::EDGE_STAGES;
   localparam logic [1:0] LO_I = 2'(EDGE % 2);
   localparam logic [1:0] HI_I = 2'(EDGE % 2 + 2);
   localparam bit IS_LOW = (EDGE < 2);

   typedef struct packed {
      rsc_pkg::job_type job;
      logic             trim;
      logic             dz;
      logic             rup;
      logic             ovf;
      logic [W-1:0]     ov;
      logic [W-1:0]     s;
      logic [W-1:0]     d;
      logic [W-1:0]     r;
      logic [2*W-1:0]   prod;
      logic [DW-1:0]    dvd;
      logic [DW-1:0]    q;
   } work_type;

   function automatic work_type stage_fn(input int unsigned k, input work_type x);
      work_type      y;
      logic [W-1:0]  sl, sh, dl, dh, c, ov, n;
      logic [W:0]    t;
      logic [W:0]    sum;
      y = x;
      sl = x.job.src[LO_I];
      sh = x.job.src[HI_I];
      dl = x.job.dst[LO_I];
      dh = x.job.dst[HI_I];
      c  = IS_LOW ? x.job.clip[LO_I] : x.job.clip[HI_I];
      if (k == 0) begin
         ov     = IS_LOW ? c - dl : dh - c;
         y.trim = !x.job.status && (ov != '0) && !ov[W-1];
         y.s    = sh - sl;
         y.d    = dh - dl;
         y.dz   = (y.d == '0);
         if (!y.dz && ($signed(y.d) < $signed(ov))) ov = y.d;
         y.ov   = ov;
         y.r    = y.dz ? '0 : y.d - ov;
         y.rup  = $signed(y.s) < $signed(y.d << FRACTION_BITS);
      end else if (k == 1) begin
         y.prod = {{W{1'b0}}, x.s} * {{W{1'b0}}, x.r};
      end else if (k == 2) begin
         y.ovf = (x.prod[2*W-1:W] != '0);
         sum   = x.rup ? {1'b0, x.prod[W-1:0]} + {1'b0, x.d} - {{W{1'b0}}, 1'b1}
                       : {1'b0, x.prod[W-1:0]};
         y.dvd = DW'(sum);
         y.r   = '0;
         y.q   = '0;
      end else if (k < NS - 1) begin
         for (int b = 0; b < rsc_pkg::DIV_STEP; b++) begin
            t     = {y.r, y.dvd[DW-1]};
            y.dvd = {y.dvd[DW-2:0], 1'b0};
            if (t >= {1'b0, y.d}) begin
               y.r = W'(t - {1'b0, y.d});
               y.q = {y.q[DW-2:0], 1'b1};
            end else begin
               y.r = t[W-1:0];
               y.q = {y.q[DW-2:0], 1'b0};
            end
         end
      end else begin
         n = x.dz ? '0 : x.q[W-1:0];
         if (x.trim) begin
            if (x.ovf && !x.dz) begin
               y.job.status = rsc_pkg::STATUS_OVERFLOW;
            end else if (IS_LOW) begin
               y.job.src[LO_I] = sh - n;
               y.job.dst[LO_I] = dl + x.ov;
            end else begin
               y.job.src[HI_I] = sl + n;
               y.job.dst[HI_I] = dh - x.ov;
            end
         end
      end
      return y;
   endfunction

   work_type        data_ff [NS];
   logic [NS-1:0]   valid_ff;
   logic [NS:0]     rdy;
   work_type        data_in [NS];
   work_type        head;

   always_comb begin
      head     = '0;
      head.job = in_job;
   end

   assign rdy[NS]   = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[NS-1];
   assign out_job   = data_ff[NS-1].job;

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic v_in;
      if (g == 0) begin : g_first
         assign v_in       = in_valid;
         assign data_in[g] = stage_fn(g, head);
      end else begin : g_next
         assign v_in       = valid_ff[g-1];
         assign data_in[g] = stage_fn(g, data_ff[g-1]);
      end
      assign rdy[g] = !valid_ff[g] || rdy[g+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            valid_ff[g] <= v_in;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g] && v_in) begin
            data_ff[g] <= data_in[g];
         end
      end
   end

endmodule
`default_nettype wire

/* src/scaled_rect_clipper.sv */
`default_nettype none
// channel | dir | payload                                       | handshake
// req_ch  | in  | src/dst/clip rectangles (12 x s32)            | valid/ready
// rsp_ch  | out | new src/dst rectangles, visible, status        | valid/ready
//
// One transaction per clock sustained while rsp_ch is ready. The path runs through
// the edge units in series, one per edge (left, top, right, bottom), each a setup
// stage, a 32x32 multiply stage, a dividend stage and nine 4-bit quotient stages
// of a restoring divider, then the edge update; one output register last.
// Synchronous active-high reset clears only valid bits.
// Each stage holds its transaction while the next is full; bubbles close up,
// so new requests are taken while a finished response waits and some stage is empty.
module scaled_rect_clipper #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   rsc_req_if.sink    req_ch,
   rsc_rsp_if.source  rsp_ch
);

   localparam int unsigned W = rsc_pkg::WORD_W;

   rsc_pkg::job_type   job [5];
   logic [4:0]         vld;
   logic [4:0]         rdy;

   // request fields into the internal edge-indexed form
   always_comb begin
      job[0]         = '0;
      job[0].status  = rsc_pkg::STATUS_OK;
      job[0].src[0]  = req_ch.data.src_left;
      job[0].src[1]  = req_ch.data.src_top;
      job[0].src[2]  = req_ch.data.src_right;
      job[0].src[3]  = req_ch.data.src_bottom;
      job[0].dst[0]  = req_ch.data.dst_left;
      job[0].dst[1]  = req_ch.data.dst_top;
      job[0].dst[2]  = req_ch.data.dst_right;
      job[0].dst[3]  = req_ch.data.dst_bottom;
      job[0].clip[0] = req_ch.data.clip_left;
      job[0].clip[1] = req_ch.data.clip_top;
      job[0].clip[2] = req_ch.data.clip_right;
      job[0].clip[3] = req_ch.data.clip_bottom;
   end
   assign vld[0]       = req_ch.valid;
   assign req_ch.ready = rdy[0];

   // edges in the fixed order; each sees the sizes left by the one before
   for (genvar e = 0; e < 4; e++) begin : g_edge
      rsc_edge #(
         .FRACTION_BITS(FRACTION_BITS),
         .EDGE         (e)
      ) u_edge (
         .clock    (clock),
         .reset    (reset),
         .in_valid (vld[e]),
         .in_ready (rdy[e]),
         .in_job   (job[e]),
         .out_valid(vld[e+1]),
         .out_ready(rdy[e+1]),
         .out_job  (job[e+1])
      );
   end

   // output register
   logic              out_valid_ff;
   rsc_pkg::rsp_type  out_ff;
   rsc_pkg::rsp_type  out_in;
   logic [W-1:0]      width, height;

   always_comb begin
      width               = job[4].dst[2] - job[4].dst[0];
      height              = job[4].dst[3] - job[4].dst[1];
      out_in.new_src_left   = job[4].src[0];
      out_in.new_src_top    = job[4].src[1];
      out_in.new_src_right  = job[4].src[2];
      out_in.new_src_bottom = job[4].src[3];
      out_in.new_dst_left   = job[4].dst[0];
      out_in.new_dst_top    = job[4].dst[1];
      out_in.new_dst_right  = job[4].dst[2];
      out_in.new_dst_bottom = job[4].dst[3];
      out_in.visible        = (width != '0) && !width[W-1] &&
                              (height != '0) && !height[W-1];
      out_in.status         = job[4].status;
   end

   assign rdy[4] = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rdy[4]) begin
         out_valid_ff <= vld[4];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4] && vld[4]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_ff;

endmodule
`default_nettype wire
